/* hdl/hpid_pkg.sv */
// Shared types, constants and microcode for the hysteresis/PID temperature regulator.
`timescale 1ns / 1ps
`default_nettype none

package hpid_pkg;

  // Configuration port geometry
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Program counter width and program layout
  localparam int unsigned STEP_W = 4;

  localparam logic [STEP_W-1:0] ST_LOAD  = 4'd0;
  localparam logic [STEP_W-1:0] ST_ERR   = 4'd1;
  localparam logic [STEP_W-1:0] ST_MAC0  = 4'd2;
  localparam logic [STEP_W-1:0] ST_MAC1  = 4'd3;
  localparam logic [STEP_W-1:0] ST_MAC2  = 4'd4;
  localparam logic [STEP_W-1:0] ST_GAIN  = 4'd5;
  localparam logic [STEP_W-1:0] ST_PID   = 4'd6;
  localparam logic [STEP_W-1:0] ST_ONOFF = 4'd7;
  localparam logic [STEP_W-1:0] ST_FAULT = 4'd8;
  localparam logic [STEP_W-1:0] ST_POST  = 4'd9;

  // Held command codes
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_ON   = 2'd1;
  localparam logic [1:0] CMD_OFF  = 2'd2;

  // Mode register bits
  localparam int unsigned MODE_OUTLET = 0;
  localparam int unsigned MODE_PID    = 1;
  localparam int unsigned MODE_HUM    = 2;

  // Register map, word index
  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_TARGET = 3'd1,
    REG_BAND   = 3'd2,
    REG_HLIM   = 3'd3,
    REG_HOFS   = 3'd4,
    REG_KP     = 3'd5,
    REG_KI     = 3'd6,
    REG_KD     = 3'd7
  } reg_e;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_ERR,
    OP_MAC0,
    OP_MAC1,
    OP_MAC2,
    OP_GAIN,
    OP_PID,
    OP_ONOFF,
    OP_FAULT
  } op_e;

  // Jump conditions
  typedef enum logic [1:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_FAULT,
    JC_ONOFF
  } jc_e;

  typedef struct packed {
    op_e              op;
    jc_e              jc;
    logic [STEP_W-1:0] target;
    logic             done;
  } cword_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] target_temp;
    logic [15:0] hysteresis_band;
    logic [31:0] humidity_limits;
    logic [15:0] humidity_offset;
    logic [15:0] prop_gain;
    logic [15:0] integral_coef;
    logic [15:0] derivative_coef;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] outlet_temp;
    logic               outlet_ok;
    logic signed [15:0] room_temp;
    logic               room_ok;
    logic [15:0]        humidity;
    logic               humidity_ok;
  } in_t;

  typedef struct packed {
    logic [1:0]         command;
    logic               fault;
    logic signed [15:0] drive_value;
  } out_t;

  // Sequencer to datapath control
  typedef struct packed {
    logic busy;
    op_e  op;
    logic done;
  } seq_ctl_t;

  // Datapath to sequencer branch flags
  typedef struct packed {
    logic ok;
    logic pid_mode;
  } dp_flags_t;

  // Microcode store
  function automatic cword_t ucode(input logic [STEP_W-1:0] step);
    cword_t cw;
    cw = '{op: OP_NOP, jc: JC_NEXT, target: ST_LOAD, done: 1'b1};
    unique case (step)
      ST_LOAD:  cw = '{op: OP_LOAD,  jc: JC_NEXT,   target: ST_LOAD,  done: 1'b0};
      ST_ERR:   cw = '{op: OP_ERR,   jc: JC_FAULT,  target: ST_FAULT, done: 1'b0};
      ST_MAC0:  cw = '{op: OP_MAC0,  jc: JC_ONOFF,  target: ST_ONOFF, done: 1'b0};
      ST_MAC1:  cw = '{op: OP_MAC1,  jc: JC_NEXT,   target: ST_LOAD,  done: 1'b0};
      ST_MAC2:  cw = '{op: OP_MAC2,  jc: JC_NEXT,   target: ST_LOAD,  done: 1'b0};
      ST_GAIN:  cw = '{op: OP_GAIN,  jc: JC_NEXT,   target: ST_LOAD,  done: 1'b0};
      ST_PID:   cw = '{op: OP_PID,   jc: JC_ALWAYS, target: ST_POST,  done: 1'b0};
      ST_ONOFF: cw = '{op: OP_ONOFF, jc: JC_ALWAYS, target: ST_POST,  done: 1'b0};
      ST_FAULT: cw = '{op: OP_FAULT, jc: JC_NEXT,   target: ST_LOAD,  done: 1'b0};
      ST_POST:  cw = '{op: OP_NOP,   jc: JC_NEXT,   target: ST_LOAD,  done: 1'b1};
      default:  cw = '{op: OP_NOP,   jc: JC_NEXT,   target: ST_LOAD,  done: 1'b1};
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

/* hdl/hpid_seq.sv */
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`timescale 1ns / 1ps
`default_nettype none

module hpid_seq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               hold_i,
  input  wire hpid_pkg::dp_flags_t flags_i,
  output hpid_pkg::seq_ctl_t      ctl_o
);

  logic                         busy_q, busy_d;
  logic [hpid_pkg::STEP_W-1:0]  step_q, step_d;
  hpid_pkg::cword_t             cw;
  logic                         take_jump;

  // Fetch the current control word
  assign cw = hpid_pkg::ucode(step_q);

  // Evaluate the branch condition
  always_comb begin
    unique case (cw.jc)
      hpid_pkg::JC_NEXT:   take_jump = 1'b0;
      hpid_pkg::JC_ALWAYS: take_jump = 1'b1;
      hpid_pkg::JC_FAULT:  take_jump = !flags_i.ok;
      hpid_pkg::JC_ONOFF:  take_jump = !flags_i.pid_mode;
      default:             take_jump = 1'b0;
    endcase
  end

  // Advance, jump, wait at the last step or restart
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = hpid_pkg::ST_LOAD;
    end else if (busy_q) begin
      if (cw.done) begin
        if (!hold_i) begin
          busy_d = 1'b0;
          step_d = hpid_pkg::ST_LOAD;
        end
      end else if (take_jump) begin
        step_d = cw.target;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= hpid_pkg::ST_LOAD;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  assign ctl_o.busy = busy_q;
  assign ctl_o.op   = busy_q ? cw.op : hpid_pkg::OP_NOP;
  assign ctl_o.done = busy_q && cw.done;

`ifndef SYNTHESIS
  // An idle sequencer rests at the first step
  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> step_q == hpid_pkg::ST_LOAD)
    else $error("idle sequencer not at first step");
`endif

endmodule

`default_nettype wire

/* hdl/hpid_datapath.sv */
// Datapath: sample latch, setpoint adjust, shared multiplier, PID and command state.
`timescale 1ns / 1ps
`default_nettype none

module hpid_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire hpid_pkg::in_t       smp_i,
  input  wire hpid_pkg::cfg_t      cfg_i,
  input  wire hpid_pkg::seq_ctl_t  ctl_i,
  output hpid_pkg::dp_flags_t      flags_o,
  output hpid_pkg::out_t           res_o
);

  hpid_pkg::in_t smp_q;
  logic [15:0]   tgt_q, tgt_d;
  logic [15:0]   cur_q, cur_d;
  logic          ok_q, ok_d;
  logic [15:0]   ek_q;
  logic [15:0]   acc_q, acc_d;
  logic [15:0]   pid_q, pid_d;
  logic [15:0]   e1_q, e1_d;
  logic [15:0]   e2_q, e2_d;
  logic [1:0]    cmd_q, cmd_d;
  logic          fault_q, fault_d;

  logic [15:0]   hum_lo, hum_hi, tgt_lo_adj, tgt_adj;
  logic [15:0]   d0, d1, d2;
  logic [15:0]   mul_a, mul_b;
  logic [31:0]   prod_full;
  logic [15:0]   prod;
  logic [17:0]   cur_x, tgt_x, low_x;
  logic [1:0]    onoff_cmd, pid_cmd;
  logic          prev_le0, prev_ge0, next_gt0, next_lt0;

  // Select sensor, check health, shift setpoint for humidity
  assign hum_lo     = cfg_i.humidity_limits[15:0];
  assign hum_hi     = cfg_i.humidity_limits[31:16];
  assign tgt_lo_adj = (smp_q.humidity <= hum_lo) ? cfg_i.target_temp - cfg_i.humidity_offset
                                                 : cfg_i.target_temp;
  assign tgt_adj    = (smp_q.humidity >= hum_hi) ? tgt_lo_adj + cfg_i.humidity_offset
                                                 : tgt_lo_adj;

  always_comb begin
    if (cfg_i.mode[hpid_pkg::MODE_OUTLET]) begin
      cur_d = smp_q.outlet_temp;
      ok_d  = smp_q.outlet_ok;
    end else begin
      cur_d = smp_q.room_temp;
      ok_d  = smp_q.room_ok;
    end
    tgt_d = cfg_i.target_temp;
    if (cfg_i.mode[hpid_pkg::MODE_HUM]) begin
      ok_d  = ok_d && smp_q.humidity_ok;
      tgt_d = tgt_adj;
    end
  end

  // Velocity-form coefficients, all mod 2^16
  assign d0 = 16'd1 + cfg_i.integral_coef + cfg_i.derivative_coef;
  assign d1 = ~{cfg_i.derivative_coef[14:0], 1'b0};
  assign d2 = cfg_i.derivative_coef;

  // Route operands to the shared multiplier
  always_comb begin
    unique case (ctl_i.op)
      hpid_pkg::OP_MAC0: begin mul_a = d0;              mul_b = ek_q;  end
      hpid_pkg::OP_MAC1: begin mul_a = d1;              mul_b = e1_q;  end
      hpid_pkg::OP_MAC2: begin mul_a = d2;              mul_b = e2_q;  end
      hpid_pkg::OP_GAIN: begin mul_a = cfg_i.prop_gain; mul_b = acc_q; end
      default:           begin mul_a = '0;              mul_b = '0;    end
    endcase
  end

  assign prod_full = mul_a * mul_b;
  assign prod      = prod_full[15:0];

  // On/off compare, exact over 18 bits
  assign cur_x = {{2{cur_q[15]}}, cur_q};
  assign tgt_x = {2'b00, tgt_q};
  assign low_x = tgt_x - {2'b00, cfg_i.hysteresis_band};

  always_comb begin
    if ($signed(cur_x) >= $signed(tgt_x)) begin
      onoff_cmd = hpid_pkg::CMD_OFF;
    end else if ($signed(cur_x) <= $signed(low_x)) begin
      onoff_cmd = hpid_pkg::CMD_ON;
    end else begin
      onoff_cmd = hpid_pkg::CMD_NONE;
    end
  end

  // Sign change of the drive value
  assign pid_d    = pid_q + acc_q;
  assign prev_le0 = pid_q[15] || (pid_q == '0);
  assign prev_ge0 = !pid_q[15];
  assign next_gt0 = !pid_d[15] && (pid_d != '0);
  assign next_lt0 = pid_d[15];

  always_comb begin
    priority if (prev_le0 && next_gt0) begin
      pid_cmd = hpid_pkg::CMD_ON;
    end else if (prev_ge0 && next_lt0) begin
      pid_cmd = hpid_pkg::CMD_OFF;
    end else begin
      pid_cmd = hpid_pkg::CMD_NONE;
    end
  end

  // Accumulator update
  always_comb begin
    unique case (ctl_i.op)
      hpid_pkg::OP_MAC0: acc_d = prod;
      hpid_pkg::OP_MAC1: acc_d = acc_q + prod;
      hpid_pkg::OP_MAC2: acc_d = acc_q + prod;
      hpid_pkg::OP_GAIN: acc_d = prod;
      default:           acc_d = acc_q;
    endcase
  end

  // Commit regulator state
  always_comb begin
    e1_d    = e1_q;
    e2_d    = e2_q;
    cmd_d   = cmd_q;
    fault_d = fault_q;
    unique case (ctl_i.op)
      hpid_pkg::OP_PID: begin
        e2_d    = e1_q;
        e1_d    = ek_q;
        cmd_d   = pid_cmd;
        fault_d = 1'b0;
      end
      hpid_pkg::OP_ONOFF: begin
        cmd_d   = onoff_cmd;
        fault_d = 1'b0;
      end
      hpid_pkg::OP_FAULT: begin
        fault_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      smp_q <= smp_i;
    end
    if (ctl_i.op == hpid_pkg::OP_LOAD) begin
      tgt_q <= tgt_d;
      cur_q <= cur_d;
      ok_q  <= ok_d;
    end
    if (ctl_i.op == hpid_pkg::OP_ERR) begin
      ek_q <= tgt_q - cur_q;
    end
    acc_q <= acc_d;
  end

  // Regulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pid_q   <= '0;
      e1_q    <= '0;
      e2_q    <= '0;
      cmd_q   <= hpid_pkg::CMD_NONE;
      fault_q <= 1'b1;
    end else begin
      if (ctl_i.op == hpid_pkg::OP_PID) begin
        pid_q <= pid_d;
      end
      e1_q    <= e1_d;
      e2_q    <= e2_d;
      cmd_q   <= cmd_d;
      fault_q <= fault_d;
    end
  end

  assign flags_o.ok       = ok_q;
  assign flags_o.pid_mode = cfg_i.mode[hpid_pkg::MODE_PID];

  assign res_o.command     = cmd_q;
  assign res_o.fault       = fault_q;
  assign res_o.drive_value = pid_q;

`ifndef SYNTHESIS
  // A fault step leaves the drive value and error history alone
  a_fault_keeps_pid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.op == hpid_pkg::OP_FAULT |=> $stable(pid_q) && $stable(e1_q) && $stable(e2_q))
    else $error("fault step disturbed PID state");

  // The command register never holds the unused code
  a_cmd_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_q == hpid_pkg::CMD_NONE || cmd_q == hpid_pkg::CMD_ON || cmd_q == hpid_pkg::CMD_OFF)
    else $error("command register holds an unused code");
`endif

endmodule

`default_nettype wire

/* hdl/hysteresis_pid_temperature_regulator.sv */
// Top level: APB register file, transaction handshakes, sequencer and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Temperature regulator with on/off hysteresis and velocity-form PID modes.
// Each accepted sample transaction yields exactly one result transaction
// carrying the held command, the fault flag and the current drive value.
// A microcoded sequencer steps a single datapath with one shared 16x16
// multiplier: a PID sample runs three multiply-accumulates and the gain
// multiply one per cycle through that multiplier, an on/off sample leaves
// it after the first multiply and a faulted sample never reaches it. A new
// sample is accepted in the cycle the previous one completes. A finished
// result waits in the output register; the sequencer holds on its last
// step while that register is still full and stalled. Registers sit at
// byte address 4*index on the APB port and must only be written while no
// sample is in flight.
module hysteresis_pid_temperature_regulator (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Sample channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire hpid_pkg::in_t                in_data_i,
  // Result channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output hpid_pkg::out_t                    out_data_o,
  // Configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [hpid_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [hpid_pkg::DATA_W-1:0]  pwdata,
  output logic [hpid_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  hpid_pkg::cfg_t      cfg_q;
  hpid_pkg::seq_ctl_t  ctl;
  hpid_pkg::dp_flags_t flags;
  hpid_pkg::out_t      res;
  hpid_pkg::out_t      out_q;
  hpid_pkg::reg_e      reg_sel;
  logic                out_valid_q;
  logic                cfg_wr, in_acc, out_acc, hold, finish;

  // Register access decode
  assign pready  = 1'b1;
  assign reg_sel = hpid_pkg::reg_e'(paddr[hpid_pkg::ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        hpid_pkg::REG_MODE:   cfg_q.mode            <= pwdata[2:0];
        hpid_pkg::REG_TARGET: cfg_q.target_temp     <= pwdata[15:0];
        hpid_pkg::REG_BAND:   cfg_q.hysteresis_band <= pwdata[15:0];
        hpid_pkg::REG_HLIM:   cfg_q.humidity_limits <= pwdata;
        hpid_pkg::REG_HOFS:   cfg_q.humidity_offset <= pwdata[15:0];
        hpid_pkg::REG_KP:     cfg_q.prop_gain       <= pwdata[15:0];
        hpid_pkg::REG_KI:     cfg_q.integral_coef   <= pwdata[15:0];
        hpid_pkg::REG_KD:     cfg_q.derivative_coef <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_sel)
      hpid_pkg::REG_MODE:   prdata = {29'd0, cfg_q.mode};
      hpid_pkg::REG_TARGET: prdata = {16'd0, cfg_q.target_temp};
      hpid_pkg::REG_BAND:   prdata = {16'd0, cfg_q.hysteresis_band};
      hpid_pkg::REG_HLIM:   prdata = cfg_q.humidity_limits;
      hpid_pkg::REG_HOFS:   prdata = {16'd0, cfg_q.humidity_offset};
      hpid_pkg::REG_KP:     prdata = {16'd0, cfg_q.prop_gain};
      hpid_pkg::REG_KI:     prdata = {16'd0, cfg_q.integral_coef};
      hpid_pkg::REG_KD:     prdata = {16'd0, cfg_q.derivative_coef};
      default:              prdata = '0;
    endcase
  end

  // Handshakes: hold the last step while the result slot is full and stalled
  assign hold       = out_valid_q && out_stall_i;
  assign finish     = ctl.done && !hold;
  assign in_stall_o = ctl.busy && !finish;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;

  hpid_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .hold_i  (hold),
    .flags_i (flags),
    .ctl_o   (ctl)
  );

  hpid_datapath u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_acc),
    .smp_i   (in_data_i),
    .cfg_i   (cfg_q),
    .ctl_i   (ctl),
    .flags_o (flags),
    .res_o   (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // An accepted sample starts the sequencer
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> ctl.busy)
    else $error("accepted sample did not start the sequencer");

  // A result appears only after a completed program
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(finish))
    else $error("result raised without a completed program");

  // A held last step keeps the sequencer busy
  a_hold_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.done && hold && !in_acc |=> ctl.busy)
    else $error("sequencer left the last step while the result slot was full");
`endif

endmodule

`default_nettype wire
